### design/lcpfs_pkg.sv
// shared types, constants and codes for the led cube pwm fade scanner
package lcpfs_pkg;

	localparam int NUM_LEDS     = 64;
	localparam int LEVELS       = 4;
	localparam int COLUMNS      = 4;
	localparam int GROUPS       = 4;
	localparam int SELECT_WORDS = 4;

	localparam int LED_W = $clog2(NUM_LEDS);
	localparam int LVL_W = $clog2(LEVELS);
	localparam int COL_W = $clog2(COLUMNS);
	localparam int GRP_W = 2;
	localparam int SEL_W = $clog2(SELECT_WORDS);

	localparam int LEVEL_W = 8;
	localparam int DELTA_W = 9;
	localparam int ERR_W   = 10;
	localparam int HOLD_W  = 9;
	localparam int PINS_W  = 4;
	localparam int WIDE_W  = 12;

	localparam logic [PINS_W-1:0] SELECT_ON = 4'd15;

	typedef enum logic [1:0] {
		REQ_BEGIN = 2'd0,
		REQ_LOAD  = 2'd1,
		REQ_FRAME = 2'd2,
		REQ_SCAN  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		CFG_PWM_RES   = 2'd0,
		CFG_HOLD_RATE = 2'd1,
		CFG_FADE_MODE = 2'd2
	} cfg_idx_t;

	localparam logic [1:0] MODE_NONE   = 2'd0;
	localparam logic [1:0] MODE_SINGLE = 2'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FADE_RD,
		ST_FADE_WR,
		ST_RATE,
		ST_FRAME_OUT,
		ST_SCAN_RD,
		ST_SCAN_ACC,
		ST_SCAN_OUT,
		ST_SEL_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic fade_rd;
		logic fade_wr;
		logic rate_upd;
		logic scan_rd;
		logic scan_acc;
		logic push_frame;
		logic push_mask;
		logic push_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic led_last;
		logic rate_stop;
		logic lvl_zero;
		logic col_zero;
		logic sel_last;
		logic frame_fade;
	} dp_status_t;

endpackage

### design/lcpfs_ctrl.sv
// controller state machine sequencing frame fades and scan slices
module lcpfs_ctrl
	import lcpfs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_req,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;
	req_t   req;

	assign req = req_t'(in_req);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (req)
						REQ_FRAME: state_d = status.frame_fade ? ST_FADE_RD : ST_FRAME_OUT;
						REQ_SCAN:  state_d = ST_SCAN_RD;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_FADE_RD: state_d = ST_FADE_WR;
			ST_FADE_WR: state_d = status.led_last ? ST_RATE : ST_FADE_RD;
			ST_RATE:    state_d = status.rate_stop ? ST_FRAME_OUT : ST_FADE_RD;
			ST_FRAME_OUT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN_RD:  state_d = ST_SCAN_ACC;
			ST_SCAN_ACC: state_d = status.lvl_zero ? ST_SCAN_OUT : ST_SCAN_RD;
			ST_SCAN_OUT: begin
				if (status.out_free) begin
					state_d = status.col_zero ? ST_SEL_OUT : ST_SCAN_RD;
				end
			end
			ST_SEL_OUT: begin
				if (status.out_free && status.sel_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		in_ready   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_FADE_RD:   cmd.fade_rd    = 1'b1;
			ST_FADE_WR:   cmd.fade_wr    = 1'b1;
			ST_RATE:      cmd.rate_upd   = 1'b1;
			ST_FRAME_OUT: cmd.push_frame = status.out_free;
			ST_SCAN_RD:   cmd.scan_rd    = 1'b1;
			ST_SCAN_ACC:  cmd.scan_acc   = 1'b1;
			ST_SCAN_OUT:  cmd.push_mask  = status.out_free;
			ST_SEL_OUT:   cmd.push_sel   = status.out_free;
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### design/lcpfs_datapath.sv
// led memories, fade and rate arithmetic, scan counters and output register
module lcpfs_datapath
	import lcpfs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [1:0]        cfg_addr,
	input  logic [7:0]        cfg_wdata,
	input  logic [31:0]       in_data,
	input  logic [1:0]        in_req,
	input  dp_cmd_t           cmd,
	output dp_status_t        status,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PINS_W-1:0] out_pins,
	output logic              out_last,
	output logic              out_done
);

	function automatic logic signed [ERR_W-1:0] sat10(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(511);
		lo = -WIDE_W'(512);
		if (v > hi) begin
			sat10 = ERR_W'(511);
		end else if (v < lo) begin
			sat10 = -ERR_W'(512);
		end else begin
			sat10 = v[ERR_W-1:0];
		end
	endfunction

	// configuration
	logic [7:0] pwm_res_q;
	logic [7:0] hold_rate_q;
	logic [1:0] fade_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwm_res_q   <= 8'd64;
			hold_rate_q <= 8'd0;
			fade_mode_q <= MODE_NONE;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_addr))
				CFG_PWM_RES:   pwm_res_q   <= cfg_wdata;
				CFG_HOLD_RATE: hold_rate_q <= cfg_wdata;
				CFG_FADE_MODE: fade_mode_q <= cfg_wdata[1:0];
				default: begin
				end
			endcase
		end
	end

	// input fields
	logic [LED_W-1:0]   in_idx;
	logic [LEVEL_W-1:0] in_start;
	logic [LEVEL_W-1:0] in_end;
	req_t               req;

	assign in_idx   = in_data[5:0];
	assign in_start = in_data[13:6];
	assign in_end   = in_data[21:14];
	assign req      = req_t'(in_req);

	logic [LEVEL_W-1:0] phase_q;
	logic [GRP_W-1:0]   grp_q;

	always_ff @(posedge clk) begin
		if (cmd.accept && req == REQ_SCAN) begin
			phase_q <= in_data[29:22];
			grp_q   <= in_data[31:30];
		end
	end

	// led memories
	logic [LEVEL_W-1:0]        bright_mem [NUM_LEDS];
	logic signed [DELTA_W-1:0] delta_mem  [NUM_LEDS];
	logic signed [ERR_W-1:0]   err_mem    [NUM_LEDS];

	logic [LEVEL_W-1:0]        b_rd_q;
	logic signed [DELTA_W-1:0] d_rd_q;
	logic signed [ERR_W-1:0]   e_rd_q;

	logic [LED_W-1:0] led_q;
	logic [COL_W-1:0] col_q;
	logic [LVL_W-1:0] lvl_q;
	logic [SEL_W-1:0] sel_q;
	logic [LEVELS-1:0] mask_q;

	logic                      load_we;
	logic [LED_W-1:0]          wr_addr;
	logic [LEVEL_W-1:0]        wr_bright;
	logic signed [ERR_W-1:0]   wr_err;
	logic signed [DELTA_W-1:0] load_delta;
	logic                      rd_en;
	logic [LED_W-1:0]          rd_addr;
	logic [LED_W-1:0]          scan_pos;

	assign load_we    = cmd.accept && req == REQ_LOAD;
	assign wr_addr    = cmd.fade_wr ? led_q : in_idx;
	assign load_delta = $signed({1'b0, in_end}) - $signed({1'b0, in_start});

	// column + group * columns + level * columns * groups
	assign scan_pos = LED_W'(int'(col_q) + int'(grp_q) * COLUMNS
		+ int'(lvl_q) * (COLUMNS * GROUPS));
	assign rd_en    = cmd.fade_rd || cmd.scan_rd;
	assign rd_addr  = cmd.scan_rd ? scan_pos : led_q;

	// fade arithmetic on the registered read
	logic signed [WIDE_W-1:0] res_w;
	logic signed [WIDE_W-1:0] fade_sum;
	logic signed [WIDE_W-1:0] fade_twice;
	logic signed [WIDE_W-1:0] fade_e;
	logic [LEVEL_W-1:0]       fade_b;

	assign res_w      = $signed({4'b0, pwm_res_q});
	assign fade_sum   = $signed({{(WIDE_W-ERR_W){e_rd_q[ERR_W-1]}}, e_rd_q})
		+ $signed({{(WIDE_W-DELTA_W){d_rd_q[DELTA_W-1]}}, d_rd_q});
	assign fade_twice = fade_sum <<< 1;

	always_comb begin
		fade_b = b_rd_q;
		fade_e = fade_sum;
		if (d_rd_q > 0) begin
			if (!(fade_twice < res_w)) begin
				if (b_rd_q != 8'd255) begin
					fade_b = b_rd_q + 8'd1;
				end
				fade_e = fade_sum - res_w;
			end
		end else begin
			if (!(fade_twice > -res_w)) begin
				if (b_rd_q != 8'd0) begin
					fade_b = b_rd_q - 8'd1;
				end
				fade_e = fade_sum + res_w;
			end
		end
	end

	assign wr_bright = cmd.fade_wr ? fade_b : in_start;
	assign wr_err    = cmd.fade_wr ? sat10(fade_e) : '0;

	always_ff @(posedge clk) begin
		if (load_we || cmd.fade_wr) begin
			bright_mem[wr_addr] <= wr_bright;
			err_mem[wr_addr]    <= wr_err;
		end
		if (load_we) begin
			delta_mem[wr_addr] <= load_delta;
		end
		if (rd_en) begin
			b_rd_q <= bright_mem[rd_addr];
			d_rd_q <= delta_mem[rd_addr];
			e_rd_q <= err_mem[rd_addr];
		end
	end

	// rate bresenham and hold count
	logic signed [ERR_W-1:0]  rate_err_q;
	logic [HOLD_W-1:0]        hold_q;
	logic signed [WIDE_W-1:0] rate_sum;
	logic                     rate_tick;
	logic [HOLD_W-1:0]        hold_inc;
	logic                     done_now;
	logic                     single;

	assign rate_sum  = $signed({{(WIDE_W-ERR_W){rate_err_q[ERR_W-1]}}, rate_err_q})
		+ $signed({4'b0, hold_rate_q});
	assign rate_tick = !((rate_sum <<< 1) < res_w);
	assign hold_inc  = (hold_q == {HOLD_W{1'b1}}) ? hold_q : hold_q + 1'b1;
	assign done_now  = hold_q > {1'b0, hold_rate_q};
	assign single    = fade_mode_q == MODE_SINGLE || hold_rate_q == 8'd0;

	logic done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_err_q <= '0;
			hold_q     <= '0;
			done_q     <= 1'b0;
			led_q      <= '0;
			col_q      <= '0;
			lvl_q      <= '0;
			sel_q      <= '0;
			mask_q     <= '0;
		end else begin
			if (cmd.accept) begin
				case (req)
					REQ_BEGIN: begin
						hold_q     <= '0;
						rate_err_q <= '0;
					end
					REQ_FRAME: begin
						done_q <= done_now;
						led_q  <= '0;
						if (!done_now && fade_mode_q == MODE_NONE) begin
							hold_q <= hold_inc;
						end
					end
					REQ_SCAN: begin
						col_q  <= COL_W'(COLUMNS - 1);
						lvl_q  <= LVL_W'(LEVELS - 1);
						sel_q  <= '0;
						mask_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.fade_wr) begin
				led_q <= led_q + 1'b1;
			end
			if (cmd.rate_upd) begin
				led_q <= '0;
				if (rate_tick) begin
					hold_q     <= hold_inc;
					rate_err_q <= sat10(rate_sum - res_w);
				end else begin
					rate_err_q <= sat10(rate_sum);
				end
			end
			if (cmd.scan_acc) begin
				mask_q[lvl_q] <= phase_q < b_rd_q;
				lvl_q         <= lvl_q - 1'b1;
			end
			if (cmd.push_mask) begin
				mask_q <= '0;
				lvl_q  <= LVL_W'(LEVELS - 1);
				col_q  <= col_q - 1'b1;
			end
			if (cmd.push_sel) begin
				sel_q <= sel_q + 1'b1;
			end
		end
	end

	// output register, frees the input side while a result waits
	logic              out_valid_q;
	logic [PINS_W-1:0] out_pins_q;
	logic              out_last_q;
	logic              out_done_q;
	logic              push;

	assign push = cmd.push_frame || cmd.push_mask || cmd.push_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_pins_q <= '0;
			out_last_q <= 1'b0;
			out_done_q <= 1'b0;
			if (cmd.push_frame) begin
				out_done_q <= done_q;
			end
			if (cmd.push_mask) begin
				out_pins_q <= PINS_W'(mask_q);
			end
			if (cmd.push_sel) begin
				out_pins_q <= (sel_q == grp_q) ? SELECT_ON : '0;
				out_last_q <= sel_q == SEL_W'(SELECT_WORDS - 1);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_pins  = out_pins_q;
	assign out_last  = out_last_q;
	assign out_done  = out_done_q;

	assign status.out_free   = !out_valid_q || out_ready;
	assign status.led_last   = led_q == LED_W'(NUM_LEDS - 1);
	assign status.rate_stop  = rate_tick || single;
	assign status.lvl_zero   = lvl_q == '0;
	assign status.col_zero   = col_q == '0;
	assign status.sel_last   = sel_q == SEL_W'(SELECT_WORDS - 1);
	assign status.frame_fade = !done_now && fade_mode_q != MODE_NONE;

endmodule

### design/led_cube_pwm_fade_scanner.sv
// top level: begin and load items leave the input side ready; a frame result is pushed
// directly in mode 0 and when done, else after fade passes that read and write back
// each led in turn, plus one rate step per pass. a scan slice pushes a level word per
// column (one memory read per level), then the select words; the next item is taken
// while the last result waits in the output register.
// arst_n clears control state and config to reset values; led memories hold no reset.
module led_cube_pwm_fade_scanner
	import lcpfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	// led_index[5:0], start_level[13:6], end_level[21:14], pwm_phase[29:22], group[31:30]
	input  logic [31:0] s_tdata,
	// req_type[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// level_pins[3:0], zero fill[7:4]
	output logic [7:0]  m_tdata,
	// pattern_done[0]
	output logic [0:0]  m_tuser,
	output logic        m_tlast
);

	dp_cmd_t           cmd;
	dp_status_t        status;
	logic [PINS_W-1:0] pins;

	lcpfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_req   (s_tuser),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lcpfs_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.in_data   (s_tdata),
		.in_req    (s_tuser),
		.cmd       (cmd),
		.status    (status),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pins  (pins),
		.out_last  (m_tlast),
		.out_done  (m_tuser[0])
	);

	assign m_tdata = {4'b0, pins};

endmodule

### design/lcpfs_checker.sv
// port-level checker for the led cube pwm fade scanner, bound to the top level
module lcpfs_checker
	import lcpfs_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("stalled result changed");

	// the latch word is a group-select word
	a_last_select: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata == 8'd15 || m_tdata == 8'd0)
		else $error("latch word is not a select word");

	// a done frame result carries no pins and no latch
	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tlast && m_tdata == 8'd0)
		else $error("done result has pins or latch");

	// a scan transaction keeps the input side busy
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == REQ_SCAN |=> !s_tready)
		else $error("input accepted during scan");

	// begin and load transactions leave the input side ready in the next cycle
	a_quick_items: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == REQ_BEGIN || s_tuser == REQ_LOAD) |=> s_tready)
		else $error("begin or load item stalled input");

endmodule

bind led_cube_pwm_fade_scanner lcpfs_checker u_lcpfs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
